FILE: rtl/bfx_pkg.sv
// Shared types, constants and helpers for the extended tape-language execute unit.
// No dependencies; used by bfx_ctrl, bfx_dpath and the top level.
package bfx_pkg;

    localparam int TAPE_DEPTH         = 65536;
    localparam int OFFSET_TABLE_WIDTH = 1024;
    localparam int PTR_W              = $clog2(TAPE_DEPTH);
    localparam int OFF_LIM            = OFFSET_TABLE_WIDTH / 2;
    localparam int CELL_W             = 32;

    // instruction codes
    localparam logic [3:0] CMD_HALT     = 4'd0;
    localparam logic [3:0] CMD_ADD      = 4'd1;
    localparam logic [3:0] CMD_MOVE     = 4'd2;
    localparam logic [3:0] CMD_READ     = 4'd3;
    localparam logic [3:0] CMD_WRITE    = 4'd4;
    localparam logic [3:0] CMD_OPEN     = 4'd5;
    localparam logic [3:0] CMD_CLOSE    = 4'd6;
    localparam logic [3:0] CMD_SETCONST = 4'd7;
    localparam logic [3:0] CMD_MULADD   = 4'd8;
    localparam logic [3:0] CMD_SEEK     = 4'd9;
    localparam logic [3:0] CMD_SLEEP    = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_CELL_MASK = 2'd0;
    localparam logic [1:0] CFG_EOF_KEEP  = 2'd1;
    localparam logic [1:0] CFG_EOF_VALUE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic clr_we;     // write zero at clear address, advance it
        logic accept;     // latch the input item, restart seek count
        logic rd_tgt;     // read address is pointer + offset
        logic lat_cur;    // read data is the current cell
        logic lat_tgt;    // read data is the target cell, form product
        logic exec;       // perform write / pointer move, set flags
        logic seek_move;  // pointer += step during seek
        logic seek_fail;  // seek gave up
        logic lat_cell;   // read data is the final cell
        logic load_out;   // move result into output register
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_seek;
        logic cell_nz;
        logic seek_limit;
        logic out_free;
    } t_stat;

    // Saturate the raw offset and reduce it to a pointer step.
    function automatic logic [PTR_W-1:0] off_step(input logic signed [10:0] raw);
        int v;
        logic [31:0] w;
        v = int'(raw);
        if (v > OFF_LIM) v = OFF_LIM;
        if (v < -OFF_LIM) v = -OFF_LIM;
        w = 32'(v);
        return w[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/bfx_ctrl.sv
// Sequencer for the execute unit: clearing sweep, per-item steps and seek walk.
// Depends on bfx_pkg; drives bfx_dpath through t_ctrl / t_stat.
module bfx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bfx_pkg::t_stat i_stat,
    output bfx_pkg::t_ctrl o_ctrl
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CUR  = 3'd2;
    localparam logic [2:0] S_TGT  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_TEST = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_CLR: begin
                o_ctrl.clr_we = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.accept = 1'b1;
                    n_state       = S_CUR;
                end
            end
            S_CUR: begin
                o_ctrl.lat_cur = 1'b1;
                o_ctrl.rd_tgt  = 1'b1;
                n_state        = S_TGT;
            end
            S_TGT: begin
                o_ctrl.lat_tgt = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                // seek tests the cell just read; everything else just reports it
                if (i_stat.is_seek && i_stat.cell_nz && !i_stat.seek_limit) begin
                    o_ctrl.seek_move = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_ctrl.seek_fail = i_stat.is_seek && i_stat.cell_nz;
                    o_ctrl.lat_cell  = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

FILE: rtl/bfx_dpath.sv
// Datapath: tape memory, pointer, config registers, multiplier and output register.
// Depends on bfx_pkg; sequenced by bfx_ctrl.
module bfx_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfx_pkg::t_ctrl              i_ctrl,
    output bfx_pkg::t_stat              o_stat,
    input  logic [3:0]                  i_command,
    input  logic [31:0]                 i_amount,
    input  logic [10:0]                 i_offset,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_in_eof,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid_item,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic                        o_take_jump,
    output logic                        o_halted,
    output logic [31:0]                 o_cell_value,
    output logic [31:0]                 o_delay_ticks,
    output logic                        o_seek_fail
);

    localparam int PW = bfx_pkg::PTR_W;
    localparam int CW = bfx_pkg::CELL_W;

    logic [CW-1:0] r_tape [bfx_pkg::TAPE_DEPTH];
    logic [CW-1:0] r_rd;

    logic [PW-1:0] r_clr_cnt;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_seek_cnt;

    logic [CW-1:0] r_cell_mask;
    logic          r_eof_keep;
    logic [CW-1:0] r_eof_value;

    logic [3:0]    r_cmd;
    logic [CW-1:0] r_amt;
    logic [10:0]   r_off;
    logic [7:0]    r_byte;
    logic          r_eof;

    logic [CW-1:0] r_cur;
    logic [CW-1:0] r_tgt;
    logic [CW-1:0] r_prod;
    logic [CW-1:0] r_cell;

    logic          r_ov, r_tj, r_hl, r_sf;
    logic [7:0]    r_ob;
    logic [CW-1:0] r_dl;

    logic          r_m_valid;
    logic          r_m_ov, r_m_tj, r_m_hl, r_m_sf;
    logic [7:0]    r_m_ob;
    logic [CW-1:0] r_m_cell, r_m_dl;

    logic [PW-1:0] tgt_addr;
    logic [PW-1:0] step;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic [CW-1:0] wr_data;
    logic          wr_en;
    logic          cur_nz;

    assign tgt_addr = r_ptr + bfx_pkg::off_step(r_off);
    assign step     = r_amt[PW-1:0];
    assign rd_addr  = i_ctrl.rd_tgt ? tgt_addr : r_ptr;
    assign cur_nz   = |(r_cur & r_cell_mask);

    // execute-step write port; the clearing sweep shares it
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = '0;
        if (i_ctrl.clr_we) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
        end else if (i_ctrl.exec) begin
            unique case (r_cmd)
                bfx_pkg::CMD_ADD: begin
                    wr_en   = 1'b1;
                    wr_data = r_cur + r_amt;
                end
                bfx_pkg::CMD_READ: begin
                    wr_en   = !r_eof || !r_eof_keep;
                    wr_data = r_eof ? r_eof_value : {{(CW-8){1'b0}}, r_byte};
                end
                bfx_pkg::CMD_SETCONST: begin
                    wr_en   = 1'b1;
                    wr_addr = tgt_addr;
                    wr_data = r_amt;
                end
                bfx_pkg::CMD_MULADD: begin
                    wr_en   = cur_nz;
                    wr_addr = tgt_addr;
                    wr_data = r_tgt + r_prod;
                end
                bfx_pkg::CMD_SLEEP: begin
                    wr_en   = 1'b1;
                    wr_addr = tgt_addr;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_tape[wr_addr] <= wr_data;
        r_rd <= r_tape[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_ptr       <= '0;
            r_seek_cnt  <= '0;
            r_cell_mask <= '1;
            r_eof_keep  <= 1'b1;
            r_eof_value <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_ctrl.clr_we) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_ctrl.exec && r_cmd == bfx_pkg::CMD_MOVE) r_ptr <= r_ptr + step;
            if (i_ctrl.seek_move) begin
                r_ptr      <= r_ptr + step;
                r_seek_cnt <= r_seek_cnt + 1'b1;
            end
            if (i_ctrl.accept) r_seek_cnt <= '0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfx_pkg::CFG_CELL_MASK: r_cell_mask <= i_cfg_data;
                    bfx_pkg::CFG_EOF_KEEP:  r_eof_keep  <= i_cfg_data[0];
                    bfx_pkg::CFG_EOF_VALUE: r_eof_value <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctrl.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= i_command;
            r_amt  <= i_amount;
            r_off  <= i_offset;
            r_byte <= i_in_byte;
            r_eof  <= i_in_eof;
            r_sf   <= 1'b0;
        end
        if (i_ctrl.lat_cur) r_cur <= r_rd;
        if (i_ctrl.lat_tgt) begin
            r_tgt  <= r_rd;
            r_prod <= CW'(r_cur * r_amt);
        end
        if (i_ctrl.exec) begin
            r_ov <= (r_cmd == bfx_pkg::CMD_WRITE);
            r_ob <= (r_cmd == bfx_pkg::CMD_WRITE) ? r_cur[7:0] : 8'd0;
            r_tj <= ((r_cmd == bfx_pkg::CMD_OPEN) && !cur_nz)
                 || ((r_cmd == bfx_pkg::CMD_CLOSE) && cur_nz);
            r_hl <= (r_cmd == bfx_pkg::CMD_HALT);
            r_dl <= (r_cmd == bfx_pkg::CMD_SLEEP) ? r_prod : '0;
        end
        if (i_ctrl.seek_fail) r_sf <= 1'b1;
        if (i_ctrl.lat_cell) r_cell <= r_rd;
        if (i_ctrl.load_out) begin
            r_m_ov   <= r_ov;
            r_m_ob   <= r_ob;
            r_m_tj   <= r_tj;
            r_m_hl   <= r_hl;
            r_m_cell <= r_cell;
            r_m_dl   <= r_dl;
            r_m_sf   <= r_sf;
        end
    end

    assign o_stat.clr_last   = (r_clr_cnt == PW'(bfx_pkg::TAPE_DEPTH - 1));
    assign o_stat.is_seek    = (r_cmd == bfx_pkg::CMD_SEEK);
    assign o_stat.cell_nz    = |(r_rd & r_cell_mask);
    // zero step, or this is the last of TAPE_DEPTH tests
    assign o_stat.seek_limit = (step == '0) || (r_seek_cnt == PW'(bfx_pkg::TAPE_DEPTH - 1));
    assign o_stat.out_free   = !r_m_valid || i_out_ready;

    assign o_out_valid_item = r_m_valid;
    assign o_out_valid      = r_m_ov;
    assign o_out_byte       = r_m_ob;
    assign o_take_jump      = r_m_tj;
    assign o_halted         = r_m_hl;
    assign o_cell_value     = r_m_cell;
    assign o_delay_ticks    = r_m_dl;
    assign o_seek_fail      = r_m_sf;

endmodule

FILE: rtl/bf_extended_execute_unit_top.sv
//  channel | direction | handshake                    | payload
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata: amount,offset,in_byte; tuser: command,in_eof
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: out_byte..seek_fail; tuser: out_valid; tlast: halted
//  cfg     | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  An item goes through cell read, target read, multiply, write, readback, test and output.
//  Seek repeats readback and test for each further cell tested (one tape read port, registered read).
//  After reset the tape is zeroed by a sweep over all 65536 cells; s_axis_tready stays low meanwhile.
//  One item is in work at a time; a finished item waits in the output register while the next runs.
//  Config writes are taken in any cycle.
// Top level; depends on bfx_pkg, bfx_ctrl, bfx_dpath.
module bf_extended_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // amount[31:0], offset[42:32], in_byte[50:43], zero pad
    input  logic [4:0]  s_axis_tuser,   // command[3:0], in_eof[4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_byte[7:0], take_jump[8], cell_value[40:9],
                                        // delay_ticks[72:41], seek_fail[73], zero pad
    output logic        m_axis_tuser,   // out_valid
    output logic        m_axis_tlast,   // halted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    bfx_pkg::t_ctrl ctrl;
    bfx_pkg::t_stat stat;

    logic        out_byte_valid;
    logic [7:0]  out_byte;
    logic        take_jump;
    logic [31:0] cell_value;
    logic [31:0] delay_ticks;
    logic        seek_fail;

    assign o_cfg_ready = 1'b1;

    bfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    bfx_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_command        (s_axis_tuser[3:0]),
        .i_amount         (s_axis_tdata[31:0]),
        .i_offset         (s_axis_tdata[42:32]),
        .i_in_byte        (s_axis_tdata[50:43]),
        .i_in_eof         (s_axis_tuser[4]),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (m_axis_tready),
        .o_out_valid_item (m_axis_tvalid),
        .o_out_valid      (out_byte_valid),
        .o_out_byte       (out_byte),
        .o_take_jump      (take_jump),
        .o_halted         (m_axis_tlast),
        .o_cell_value     (cell_value),
        .o_delay_ticks    (delay_ticks),
        .o_seek_fail      (seek_fail)
    );

    assign m_axis_tuser = out_byte_valid;
    assign m_axis_tdata = {6'd0, seek_fail, delay_ticks, cell_value, take_jump, out_byte};

endmodule

FILE: rtl/bfx_checker.sv
// Port-level checks for the execute unit, bound to the top level.
// Depends only on the top level's ports.
module bfx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // reset starts the clearing sweep: no input taken, no item shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ready or valid high right after reset");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in two consecutive cycles");

    // each instruction raises at most one of its result flags
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $countones({m_axis_tuser, m_axis_tdata[8], m_axis_tlast,
                                      m_axis_tdata[73]}) <= 1)
        else $error("more than one result flag set");

    // delay only on sleep, which raises no flag
    a_delay_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[72:41] != 32'd0)
            |-> !m_axis_tuser && !m_axis_tlast && !m_axis_tdata[8] && !m_axis_tdata[73])
        else $error("delay reported with a flag");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

endmodule

bind bf_extended_execute_unit_top bfx_checker u_bfx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/bf_extended_execute_unit_top_tb.sv
// Self-checking bench for bf_extended_execute_unit_top: a tape/pointer model predicts each result,
// directed and random instruction streams run under several mask and EOF settings.
// Depends on bfx_pkg and the RTL of bf_extended_execute_unit_top.
module bf_extended_execute_unit_top_tb;
    import bfx_pkg::*;

    localparam int RUN_LIMIT   = 30_000_000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] amount;
        logic signed [10:0] offset;
        logic [7:0]         in_byte;
        logic               in_eof;
    } instr_t;

    typedef struct {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        take_jump;
        logic        halted;
        logic [31:0] cell_value;
        logic [31:0] delay_ticks;
        logic        seek_fail;
    } step_result_t;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [55:0] s_axis_tdata  = '0;
    logic [4:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_CELL_MASK;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        o_cfg_ready;

    bf_extended_execute_unit_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // tape model and its configuration copy
    bit [31:0]      tape_model [TAPE_DEPTH];
    bit [PTR_W-1:0] ptr_model;
    bit [31:0]      mask_model   = 32'hFFFF_FFFF;
    bit             keep_model   = 1'b1;
    bit [31:0]      eofval_model = 32'h0;

    step_result_t pending_results[$];
    int mismatches, n_items, n_results, n_jumps, n_seek_fails, n_halts;
    int rx_hold;
    bit idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("bf_extended_execute_unit_top_tb: errors");
        $finish;
    end

    // Executes one instruction on the model tape and returns what the unit should report.
    function automatic step_result_t exec_instr(instr_t it);
        step_result_t r;
        int off;
        int tested;
        logic [PTR_W-1:0] p, tgt, step;
        logic [31:0] cur;
        r = '{default: '0};
        off = int'(it.offset);
        if (off > OFF_LIM) off = OFF_LIM;
        else if (off < -OFF_LIM) off = -OFF_LIM;
        p   = ptr_model;
        tgt = p + PTR_W'(off);
        cur = tape_model[p];
        case (it.cmd)
            CMD_HALT:     r.halted = 1'b1;
            CMD_ADD:      tape_model[p] = cur + it.amount;
            CMD_MOVE:     p = p + it.amount[PTR_W-1:0];
            CMD_READ: begin
                if (!it.in_eof) tape_model[p] = {24'd0, it.in_byte};
                else if (!keep_model) tape_model[p] = eofval_model;
            end
            CMD_WRITE: begin
                r.out_valid = 1'b1;
                r.out_byte  = cur[7:0];
            end
            CMD_OPEN:     r.take_jump = ((cur & mask_model) == 0);
            CMD_CLOSE:    r.take_jump = ((cur & mask_model) != 0);
            CMD_SETCONST: tape_model[tgt] = it.amount;
            CMD_MULADD: begin
                if ((cur & mask_model) != 0) tape_model[tgt] = tape_model[tgt] + cur * it.amount;
            end
            CMD_SEEK: begin
                // depth is a power of two, so the low pointer bits of the step are the step
                step   = it.amount[PTR_W-1:0];
                tested = 0;
                while ((tape_model[p] & mask_model) != 0) begin
                    tested++;
                    if (step == 0 || tested >= TAPE_DEPTH) begin
                        r.seek_fail = 1'b1;
                        break;
                    end
                    p = p + step;
                end
            end
            CMD_SLEEP: begin
                r.delay_ticks   = it.amount * cur;
                tape_model[tgt] = 32'h0;
            end
            default: ;
        endcase
        ptr_model    = p;
        r.cell_value = tape_model[p];
        return r;
    endfunction

    function automatic instr_t mk_instr(input logic [3:0] cmd, input logic [31:0] amount,
                                        input int offset, input logic [7:0] chr, input bit eof);
        instr_t it;
        it.cmd     = cmd;
        it.amount  = amount;
        it.offset  = 11'(offset);
        it.in_byte = chr;
        it.in_eof  = eof;
        return it;
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)       it.cmd = CMD_HALT;
        else if (sel < 20) it.cmd = CMD_ADD;
        else if (sel < 32) it.cmd = CMD_MOVE;
        else if (sel < 40) it.cmd = CMD_READ;
        else if (sel < 48) it.cmd = CMD_WRITE;
        else if (sel < 56) it.cmd = CMD_OPEN;
        else if (sel < 64) it.cmd = CMD_CLOSE;
        else if (sel < 72) it.cmd = CMD_SETCONST;
        else if (sel < 80) it.cmd = CMD_MULADD;
        else if (sel < 88) it.cmd = CMD_SEEK;
        else if (sel < 95) it.cmd = CMD_SLEEP;
        else               it.cmd = 4'($urandom_range(int'(CMD_SLEEP) + 1, 15));

        // pointer walks stay short most of the time so cells get reused
        if ((it.cmd == CMD_MOVE || it.cmd == CMD_SEEK) && $urandom_range(0, 4) != 0)
            it.amount = $urandom_range(0, 12) - 6;
        else begin
            case ($urandom_range(0, 3))
                0: it.amount = $urandom_range(0, 8) - 4;
                1: begin
                    case ($urandom_range(0, 7))
                        0: it.amount = 32'h0000_0080;
                        1: it.amount = 32'h0000_0100;
                        2: it.amount = 32'h0001_0000;
                        3: it.amount = 32'h0100_0000;
                        4: it.amount = 32'h7FFF_FFFF;
                        5: it.amount = 32'h8000_0000;
                        6: it.amount = 32'hFFFF_FF00;
                        default: it.amount = 32'hFFFF_FFFF;
                    endcase
                end
                default: it.amount = $urandom();
            endcase
        end

        if ($urandom_range(0, 6) != 0) it.offset = 11'($urandom_range(0, 8) - 4);
        else                           it.offset = 11'($urandom());
        it.in_byte = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom());
        it.in_eof  = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    task automatic send_instr(input instr_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.in_byte, it.offset, it.amount};
        s_axis_tuser  <= {it.in_eof, it.cmd};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pending_results.push_back(exec_instr(it));
        n_items++;
    endtask

    // Holds off the input until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_CELL_MASK: mask_model   = val;
            CFG_EOF_KEEP:  keep_model   = val[0];
            CFG_EOF_VALUE: eofval_model = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] mask, input bit keep, input logic [31:0] eofv);
        logic [31:0] keep_word;
        drain();
        keep_word    = $urandom();
        keep_word[0] = keep;    // upper bits are don't-care for a 1-bit register
        cfg_write(CFG_CELL_MASK, mask);
        cfg_write(CFG_EOF_KEEP, keep_word);
        cfg_write(CFG_EOF_VALUE, eofv);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected %h got %h", n_results, what, want, seen);
    endtask

    task automatic compare_result(input step_result_t want, input step_result_t seen);
        if (seen.out_valid !== want.out_valid)
            flag_mismatch("out_valid", 32'(want.out_valid), 32'(seen.out_valid));
        if (seen.out_byte !== want.out_byte)
            flag_mismatch("out_byte", 32'(want.out_byte), 32'(seen.out_byte));
        if (seen.take_jump !== want.take_jump)
            flag_mismatch("take_jump", 32'(want.take_jump), 32'(seen.take_jump));
        if (seen.halted !== want.halted)
            flag_mismatch("halted", 32'(want.halted), 32'(seen.halted));
        if (seen.cell_value !== want.cell_value)
            flag_mismatch("cell_value", want.cell_value, seen.cell_value);
        if (seen.delay_ticks !== want.delay_ticks)
            flag_mismatch("delay_ticks", want.delay_ticks, seen.delay_ticks);
        if (seen.seek_fail !== want.seek_fail)
            flag_mismatch("seek_fail", 32'(want.seek_fail), 32'(seen.seek_fail));
    endtask

    // result side: check each item taken, then stall for a random count
    always @(posedge i_clk) begin : result_side
        step_result_t seen, want;
        int hold;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            seen.out_byte    = m_axis_tdata[7:0];
            seen.take_jump   = m_axis_tdata[8];
            seen.cell_value  = m_axis_tdata[40:9];
            seen.delay_ticks = m_axis_tdata[72:41];
            seen.seek_fail   = m_axis_tdata[73];
            seen.out_valid   = m_axis_tuser;
            seen.halted      = m_axis_tlast;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, cell_value", 32'h0, seen.cell_value);
            end else begin
                want = pending_results.pop_front();
                compare_result(want, seen);
                n_jumps      += int'(want.take_jump);
                n_seek_fails += int'(want.seek_fail);
                n_halts      += int'(want.halted);
            end
            n_results++;
            hold = idle_on ? $urandom_range(0, 8) : 0;
            rx_hold       <= hold;
            m_axis_tready <= (hold == 0);
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed_ops();
        send_instr(mk_instr(CMD_HALT, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_ADD, 32'h7FFF_FFFF, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_ADD, 32'h8000_0000, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_WRITE, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_CLOSE, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_OPEN, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_ADD, 32'h1, 0, 8'h00, 1'b0));      // wraps to zero
        send_instr(mk_instr(CMD_OPEN, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_MOVE, 32'hFFFF_FFFF, 0, 8'h00, 1'b0)); // wraps below cell 0
        send_instr(mk_instr(CMD_READ, 32'h0, 0, 8'hA5, 1'b0));
        send_instr(mk_instr(CMD_READ, 32'h0, 0, 8'hFF, 1'b1));     // EOF, cell kept
        // offsets past the table saturate at +/- half its width
        send_instr(mk_instr(CMD_SETCONST, 32'h8000_0000, 1023, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SETCONST, 32'hFFFF_FFFF, -1024, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_MULADD, 32'h3, 513, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SLEEP, 32'hFFFF_FFFF, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_MULADD, 32'h7, 1, 8'h00, 1'b0));   // cell is zero now
        send_instr(mk_instr(4'(int'(CMD_SLEEP) + 1), 32'hFFFF_FFFF, -1, 8'hFF, 1'b1));
        send_instr(mk_instr(4'hF, 32'hFFFF_FFFF, -1, 8'hFF, 1'b1));
        send_instr(mk_instr(CMD_MOVE, 32'h7FFF_FFFF, 0, 8'h00, 1'b0));
    endtask

    task automatic test_eof_and_mask();
        configure(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        send_instr(mk_instr(CMD_READ, 32'h0, 0, 8'h11, 1'b1));
        configure(32'h0000_00FF, 1'b0, 32'h0000_0100);
        send_instr(mk_instr(CMD_READ, 32'h0, 0, 8'h22, 1'b1));     // cell = 0x100, masked zero
        send_instr(mk_instr(CMD_OPEN, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_CLOSE, 32'h0, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_MULADD, 32'h2, 1, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SEEK, 32'h1, 0, 8'h00, 1'b0));
    endtask

    task automatic test_seek_limits();
        configure(32'hFFFF_FFFF, 1'b1, 32'h0);
        send_instr(mk_instr(CMD_SETCONST, 32'h5, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SEEK, 32'h0, 0, 8'h00, 1'b0));             // zero step fails
        send_instr(mk_instr(CMD_SEEK, 32'(TAPE_DEPTH), 0, 8'h00, 1'b0));   // full-depth step
        // two-cell orbit, both nonzero: seek walks the whole depth and gives up
        send_instr(mk_instr(CMD_MOVE, 32'(TAPE_DEPTH / 2), 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SETCONST, 32'h9, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SEEK, 32'(TAPE_DEPTH / 2), 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SETCONST, 32'h1, 1, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SEEK, 32'h1, 0, 8'h00, 1'b0));
        send_instr(mk_instr(CMD_SEEK, 32'hFFFF_FFFF, 0, 8'h00, 1'b0));
    endtask

    task automatic test_random_program(input int count, input logic [31:0] mask, input bit keep,
                                       input logic [31:0] eofv, input bit idling);
        configure(mask, keep, eofv);
        idle_on = idling;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            send_instr(random_instr());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_eof_and_mask();
        test_seek_limits();
        test_random_program(250, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
        test_random_program(250, 32'h0000_00FF, 1'b0, 32'hFFFF_FFFF, 1'b1);
        test_random_program(250, 32'h0000_007F, 1'b1, $urandom(), 1'b1);
        test_random_program(250, 32'h0000_FFFF, 1'b0, 32'h0, 1'b1);
        test_random_program(250, 32'h0000_0000, 1'b0, $urandom(), 1'b1);
        test_random_program(250, $urandom(), 1'($urandom_range(0, 1)), $urandom(), 1'b1);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d instructions, checked %0d results, %0d mismatches",
                 n_items, n_results, mismatches);
        $display("saw %0d loop jumps, %0d failed seeks, %0d halts over %s",
                 n_jumps, n_seek_fails, n_halts, "7, 8, 16, 32-bit and odd masks");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("bf_extended_execute_unit_top_tb: clean");
        end else begin
            $display("bf_extended_execute_unit_top_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bfx_pkg.sv
rtl/bfx_ctrl.sv
rtl/bfx_dpath.sv
rtl/bf_extended_execute_unit_top.sv
rtl/bfx_checker.sv
tb/bf_extended_execute_unit_top_tb.sv
